[rtl/audio_packet_deframer_seq_tracker_top_defines.svh]
// Assertion macros used by the audio packet deframer RTL.
// Needs no other file; included by the modules that carry assertions.
`ifndef AUDIO_PACKET_DEFRAMER_SEQ_TRACKER_TOP_DEFINES_SVH
`define AUDIO_PACKET_DEFRAMER_SEQ_TRACKER_TOP_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define APDST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define APDST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/apdst_pkg.sv]
// Shared constants, codes and types of the audio packet deframer.
// No dependencies; imported by every module of the block.
package apdst_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int HEADER_BYTES     = 6;
    localparam int MIN_PACKET_BYTES = 8;

    // byte counter saturates at MAX_PACKET_BYTES; length is one more
    localparam int POS_W   = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LEN_W   = POS_W + 1;
    localparam int COUNT_W = 10;

    localparam logic [15:0] HALF_RANGE = 16'h8000;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        FUNC_BYTE  = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_e;

    typedef enum logic {
        KIND_SAMPLE  = 1'b0,
        KIND_VERDICT = 1'b1
    } result_kind_e;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_TOO_SHORT  = 2'd1,
        ST_ODD_LENGTH = 2'd2,
        ST_TOO_LONG   = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        EV_FIRST    = 2'd0,
        EV_IN_ORDER = 2'd1,
        EV_GAP      = 2'd2,
        EV_REORDER  = 2'd3
    } seq_event_e;

    typedef struct packed {
        result_kind_e        kind;
        logic signed [15:0]  sample_value;
        status_e             packet_status;
        logic [15:0]         sequence_number;
        logic [31:0]         packet_timestamp;
        logic [COUNT_W-1:0]  sample_count;
        seq_event_e          sequence_event;
        logic [15:0]         dropped_now;
        logic [31:0]         received_total;
        logic [31:0]         dropped_total;
        logic [31:0]         out_of_order_total;
        logic                run_end;
    } result_t;

    // which result slots the core fills in a cycle; slot b only with slot a
    typedef struct packed {
        logic valid_a;
        logic valid_b;
    } emit_t;

endpackage

[rtl/apdst_deframer_core.sv]
// Byte-level deframer: header gather, sample assembly, length verdict and
// sequence statistics. Uses apdst_pkg; results go to apdst_result_fifo.
module apdst_deframer_core
    import apdst_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_accept,
    input  logic       in_func,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output emit_t      emit,
    output result_t    rslt_a,
    output result_t    rslt_b
);

    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [15:0]      hdr_seq_reg,  hdr_seq_next;
    logic [31:0]      hdr_ts_reg,   hdr_ts_next;
    logic [7:0]       low_byte_reg, low_byte_next;
    logic [15:0]      last_seq_reg, last_seq_next;
    logic             first_reg,    first_next;
    logic [31:0]      recv_reg,     recv_next;
    logic [31:0]      drop_reg,     drop_next;
    logic [31:0]      ooo_reg,      ooo_next;

    logic             below_max;
    logic             sample_hit;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] eff;
    logic [LEN_W-1:0] cnt_full;
    status_e          status;
    seq_event_e       seq_event;
    logic [15:0]      exp_seq;
    logic [15:0]      gap;
    logic             gap_like;
    logic             is_byte;
    result_t          sample_res;
    result_t          verdict_res;

    assign below_max = pos_reg < POS_W'(MAX_PACKET_BYTES);
    assign is_byte   = in_accept && (in_func == FUNC_BYTE);

    // header and sample gathering for the incoming byte
    always_comb begin
        hdr_seq_next  = hdr_seq_reg;
        hdr_ts_next   = hdr_ts_reg;
        low_byte_next = low_byte_reg;
        sample_hit    = 1'b0;
        if (pos_reg == POS_W'(0)) begin
            hdr_seq_next = {8'h00, in_byte};
            hdr_ts_next  = '0;
        end else if (pos_reg == POS_W'(1)) begin
            hdr_seq_next[15:8] = in_byte;
        end else if (pos_reg < POS_W'(HEADER_BYTES)) begin
            case (pos_reg[1:0])
                2'd2:    hdr_ts_next[7:0]   = in_byte;
                2'd3:    hdr_ts_next[15:8]  = in_byte;
                2'd0:    hdr_ts_next[23:16] = in_byte;
                default: hdr_ts_next[31:24] = in_byte;
            endcase
        end else if (below_max) begin
            // header length is even, so an even position holds a low byte
            if (!pos_reg[0]) begin
                low_byte_next = in_byte;
            end else begin
                sample_hit = 1'b1;
            end
        end
    end

    // length verdict
    always_comb begin
        len = {1'b0, pos_reg} + LEN_W'(1);
        eff = (len < LEN_W'(MAX_PACKET_BYTES)) ? len : LEN_W'(MAX_PACKET_BYTES);
        cnt_full = (eff > LEN_W'(HEADER_BYTES)) ?
                   ((eff - LEN_W'(HEADER_BYTES)) >> 1) : '0;
        if (len < LEN_W'(MIN_PACKET_BYTES)) begin
            status = ST_TOO_SHORT;
        end else if (len > LEN_W'(MAX_PACKET_BYTES)) begin
            status = ST_TOO_LONG;
        end else if (len[0]) begin
            status = ST_ODD_LENGTH;
        end else begin
            status = ST_ACCEPTED;
        end
    end

    // sequence classification and statistics
    always_comb begin
        exp_seq  = last_seq_reg + 16'd1;
        gap_like = ((exp_seq > HALF_RANGE) && (hdr_seq_next < HALF_RANGE)) ||
                   (hdr_seq_next > exp_seq);
        gap       = '0;
        seq_event = EV_FIRST;

        pos_next      = pos_reg;
        last_seq_next = last_seq_reg;
        first_next    = first_reg;
        recv_next     = recv_reg;
        drop_next     = drop_reg;
        ooo_next      = ooo_reg;

        if (in_accept && (in_func == FUNC_CLEAR)) begin
            last_seq_next = '0;
            first_next    = 1'b0;
            recv_next     = '0;
            drop_next     = '0;
            ooo_next      = '0;
        end else if (is_byte && !in_last) begin
            if (below_max) begin
                pos_next = pos_reg + POS_W'(1);
            end
        end else if (is_byte) begin
            pos_next = '0;
            if (status == ST_ACCEPTED) begin
                recv_next     = recv_reg + 32'd1;
                last_seq_next = hdr_seq_next;
                if (!first_reg) begin
                    first_next = 1'b1;
                end else if (hdr_seq_next == exp_seq) begin
                    seq_event = EV_IN_ORDER;
                end else if (gap_like) begin
                    seq_event = EV_GAP;
                    gap       = hdr_seq_next - exp_seq;
                    drop_next = drop_reg + {16'h0000, gap};
                end else begin
                    seq_event = EV_REORDER;
                    ooo_next  = ooo_reg + 32'd1;
                end
            end
        end
    end

    // result words
    always_comb begin
        sample_res              = '0;
        sample_res.kind         = KIND_SAMPLE;
        sample_res.sample_value = {in_byte, low_byte_reg};
        sample_res.run_end      = !in_last;

        verdict_res                    = '0;
        verdict_res.kind               = KIND_VERDICT;
        verdict_res.packet_status      = status;
        verdict_res.sequence_number    = hdr_seq_next;
        verdict_res.packet_timestamp   = hdr_ts_next;
        verdict_res.sample_count       = COUNT_W'(cnt_full);
        verdict_res.sequence_event     = seq_event;
        verdict_res.dropped_now        = gap;
        verdict_res.received_total     = recv_next;
        verdict_res.dropped_total      = drop_next;
        verdict_res.out_of_order_total = ooo_next;
        verdict_res.run_end            = 1'b1;

        emit   = '0;
        rslt_a = sample_res;
        rslt_b = verdict_res;
        if (is_byte) begin
            if (!in_last) begin
                emit.valid_a = sample_hit;
            end else if (sample_hit) begin
                emit.valid_a = 1'b1;
                emit.valid_b = 1'b1;
            end else begin
                emit.valid_a = 1'b1;
                rslt_a       = verdict_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            hdr_seq_reg  <= '0;
            hdr_ts_reg   <= '0;
            low_byte_reg <= '0;
            last_seq_reg <= '0;
            first_reg    <= 1'b0;
            recv_reg     <= '0;
            drop_reg     <= '0;
            ooo_reg      <= '0;
        end else begin
            pos_reg      <= pos_next;
            last_seq_reg <= last_seq_next;
            first_reg    <= first_next;
            recv_reg     <= recv_next;
            drop_reg     <= drop_next;
            ooo_reg      <= ooo_next;
            if (is_byte) begin
                hdr_seq_reg  <= hdr_seq_next;
                hdr_ts_reg   <= hdr_ts_next;
                low_byte_reg <= low_byte_next;
            end
        end
    end

endmodule

[rtl/apdst_result_fifo.sv]
// Result queue: takes up to two result words per cycle, releases one while out_ready is high.
// Uses apdst_pkg and the assertion macros header.
`include "audio_packet_deframer_seq_tracker_top_defines.svh"

module apdst_result_fifo
    import apdst_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  emit_t   emit,
    input  result_t rslt_a,
    input  result_t rslt_b,
    output logic    room_for_two,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    result_t               slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg,  level_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_b;
    logic [FIFO_LVL_W-1:0] push_cnt;
    logic                  pop;

    assign push_cnt     = FIFO_LVL_W'(emit.valid_a) + FIFO_LVL_W'(emit.valid_b);
    assign pop          = out_valid && out_ready;
    assign wr_ptr_b     = wr_ptr_reg + FIFO_PTR_W'(1);
    assign out_valid    = level_reg != '0;
    assign out_word     = slot_reg[rd_ptr_reg];
    assign room_for_two = level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + push_cnt - FIFO_LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid_a) begin
            slot_reg[wr_ptr_reg] <= rslt_a;
        end
        if (emit.valid_b) begin
            slot_reg[wr_ptr_b] <= rslt_b;
        end
    end

    `APDST_ASSERT(a_level_bound, aclk, aresetn, level_reg <= FIFO_LVL_W'(FIFO_DEPTH), "result queue level beyond depth")
    `APDST_ASSERT(a_no_overflow, aclk, aresetn, (level_reg + push_cnt) <= FIFO_LVL_W'(FIFO_DEPTH), "result queue overflow")
    `APDST_ASSERT(a_second_needs_first, aclk, aresetn, !emit.valid_b || emit.valid_a, "second result slot used alone")
    `APDST_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && (push_cnt == '0), level_reg == $past(level_reg) - FIFO_LVL_W'(1), "pop did not drain the queue")

endmodule

[rtl/audio_packet_deframer_seq_tracker_top.sv]
// Audio packet deframer with sequence tracker, top level.
// Uses apdst_pkg, apdst_deframer_core and apdst_result_fifo.
//
// Takes one payload byte per cycle while s_tready is high. Each accepted byte is
// decoded in the cycle it arrives and its results are written into a four-word
// result queue, which registers them before they show on the master side. A byte
// yields zero, one or two results; the only two-result case is a final byte that
// completes a sample (sample, then verdict). s_tready is high while the queue has
// room for two words, so with the master side always ready the block sustains one
// byte per cycle. Samples of a packet leave before its verdict: discard them
// downstream when the verdict is not accepted. A clear word (tuser high) zeroes the
// statistics and yields no result.
module audio_packet_deframer_seq_tracker_top
    import apdst_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tuser,   // func
    input  logic         s_tlast,   // last_byte

    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_value, packet_status, sequence_number, packet_timestamp, sample_count,
    // sequence_event, dropped_now, received_total, dropped_total,
    // out_of_order_total, zero fill
    output logic [191:0] m_tdata,
    output logic         m_tuser,   // result_kind
    output logic         m_tlast    // run_end
);

    emit_t   emit;
    result_t rslt_a;
    result_t rslt_b;
    result_t out_word;
    logic    room_for_two;
    logic    in_accept;

    assign s_tready  = room_for_two;
    assign in_accept = s_tvalid && s_tready;

    apdst_deframer_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_func   (s_tuser),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .emit      (emit),
        .rslt_a    (rslt_a),
        .rslt_b    (rslt_b)
    );

    apdst_result_fifo u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .emit         (emit),
        .rslt_a       (rslt_a),
        .rslt_b       (rslt_b),
        .room_for_two (room_for_two),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_word     (out_word)
    );

    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.run_end;
    assign m_tdata = {2'b00,
                      out_word.out_of_order_total,
                      out_word.dropped_total,
                      out_word.received_total,
                      out_word.dropped_now,
                      out_word.sequence_event,
                      out_word.sample_count,
                      out_word.packet_timestamp,
                      out_word.sequence_number,
                      out_word.packet_status,
                      out_word.sample_value};

endmodule

[sim/audio_packet_deframer_seq_tracker_top_tb.sv]
// Self-checking testbench for the audio packet deframer with sequence tracker.
// Needs apdst_pkg and the RTL top level; predicts every sample and verdict word and
// compares them with the master side, under random idling on both stream sides.
module audio_packet_deframer_seq_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import apdst_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 20;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    // tracker state mirrored from the block
    logic [POS_W-1:0] pos_r;
    logic [15:0]      hdr_seq;
    logic [31:0]      hdr_ts;
    logic [7:0]       low_byte;
    logic [15:0]      seq_last;
    logic             first_seen;
    logic [31:0]      recv_total;
    logic [31:0]      drop_total;
    logic [31:0]      reorder_total;

    result_t deframed_q[$];
    int      mismatches = 0;
    int      words_sent = 0;
    int      results_seen = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    audio_packet_deframer_seq_tracker_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_count, deframed_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void clear_tracking();
        seq_last      = '0;
        first_seen    = 1'b0;
        recv_total    = '0;
        drop_total    = '0;
        reorder_total = '0;
    endfunction

    // Predict the words one payload byte produces and queue them.
    function automatic void deframe_byte(logic [7:0] b, logic lst);
        int unsigned p;
        int unsigned len;
        int unsigned eff;
        int unsigned cnt;
        result_t     w;
        status_e     st;
        seq_event_e  ev;
        logic [15:0] gap;
        logic [15:0] nxt;
        p = pos_r;
        if (p == 0) begin
            hdr_seq = {8'h00, b};
            hdr_ts  = '0;
        end else if (p == 1) begin
            hdr_seq[15:8] = b;
        end else if (p < HEADER_BYTES) begin
            hdr_ts[8*(p-2) +: 8] = b;
        end else if (p < MAX_PACKET_BYTES) begin
            if (((p - HEADER_BYTES) & 1) == 0) begin
                low_byte = b;
            end else begin
                w = '0;
                w.kind = KIND_SAMPLE;
                w.sample_value = {b, low_byte};
                w.run_end = !lst;
                deframed_q.push_back(w);
            end
        end
        if (!lst) begin
            // counter holds at the bound once the packet runs long
            if (p < MAX_PACKET_BYTES) pos_r = POS_W'(p + 1);
            return;
        end
        len = p + 1;
        eff = (len < MAX_PACKET_BYTES) ? len : MAX_PACKET_BYTES;
        cnt = (eff > HEADER_BYTES) ? (eff - HEADER_BYTES) / 2 : 0;
        if (len < MIN_PACKET_BYTES)                st = ST_TOO_SHORT;
        else if (len > MAX_PACKET_BYTES)           st = ST_TOO_LONG;
        else if (((len - HEADER_BYTES) & 1) != 0)  st = ST_ODD_LENGTH;
        else                                       st = ST_ACCEPTED;
        ev  = EV_FIRST;
        gap = '0;
        if (st == ST_ACCEPTED) begin
            recv_total = recv_total + 1;
            if (!first_seen) begin
                first_seen = 1'b1;
            end else begin
                nxt = seq_last + 16'd1;
                if (hdr_seq == nxt) begin
                    ev = EV_IN_ORDER;
                end else if ((nxt > HALF_RANGE && hdr_seq < HALF_RANGE) || hdr_seq > nxt) begin
                    // treat as a forward jump, possibly across the wrap
                    gap = hdr_seq - nxt;
                    drop_total = drop_total + gap;
                    ev = EV_GAP;
                end else begin
                    reorder_total = reorder_total + 1;
                    ev = EV_REORDER;
                end
            end
            seq_last = hdr_seq;
        end
        w = '0;
        w.kind               = KIND_VERDICT;
        w.packet_status      = st;
        w.sequence_number    = hdr_seq;
        w.packet_timestamp   = hdr_ts;
        w.sample_count       = cnt[COUNT_W-1:0];
        w.sequence_event     = ev;
        w.dropped_now        = gap;
        w.received_total     = recv_total;
        w.dropped_total      = drop_total;
        w.out_of_order_total = reorder_total;
        w.run_end            = 1'b1;
        deframed_q.push_back(w);
        pos_r = '0;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in word %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        result_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (deframed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word %0d: kind %0b data 0x%0h",
                             results_seen, m_tuser, m_tdata);
            end else begin
                w = deframed_q.pop_front();
                check_field("result_kind", 32'(w.kind), 32'(m_tuser));
                check_field("sample_value", 32'(unsigned'(w.sample_value)),
                            32'(m_tdata[15:0]));
                check_field("packet_status", 32'(w.packet_status), 32'(m_tdata[17:16]));
                check_field("sequence_number", 32'(w.sequence_number), 32'(m_tdata[33:18]));
                check_field("packet_timestamp", w.packet_timestamp, m_tdata[65:34]);
                check_field("sample_count", 32'(w.sample_count), 32'(m_tdata[75:66]));
                check_field("sequence_event", 32'(w.sequence_event), 32'(m_tdata[77:76]));
                check_field("dropped_now", 32'(w.dropped_now), 32'(m_tdata[93:78]));
                check_field("received_total", w.received_total, m_tdata[125:94]);
                check_field("dropped_total", w.dropped_total, m_tdata[157:126]);
                check_field("out_of_order_total", w.out_of_order_total, m_tdata[189:158]);
                check_field("run_end", 32'(w.run_end), 32'(m_tlast));
            end
            results_seen++;
        end
    end

    // Drive one word at the falling edge, hold it until taken, then predict.
    task automatic send_word(func_e f, logic [7:0] b, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = b;
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
        if (f == FUNC_CLEAR) clear_tracking();
        else deframe_byte(b, lst);
        words_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Send a packet; a clear word goes in ahead of byte clear_at when that is in range.
    task automatic send_packet(logic [15:0] seq, logic [31:0] ts, int len,
                               logic [15:0] first_sample, int clear_at);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            if (i == clear_at)
                send_word(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
            if (i < 2)       b = seq[8*i +: 8];
            else if (i < 6)  b = ts[8*(i-2) +: 8];
            else if (i < 8)  b = first_sample[8*(i-6) +: 8];
            else             b = 8'($urandom_range(255));
            send_word(FUNC_BYTE, b, i == len - 1);
        end
    endtask

    task automatic wait_for_results();
        while (deframed_q.size() != 0) @(negedge aclk);
    endtask

    task automatic test_header_extremes();
        send_packet(16'hFFFF, 32'hFFFF_FFFF, 8, 16'h8000, -1);
        // clear lands inside the packet: gathering goes on, stats restart
        send_packet(16'h0000, 32'h0000_0000, 8, 16'h7FFF, 7);
    endtask

    task automatic test_length_rejects();
        send_packet(16'hA55A, 32'h1234_5678, 1, 16'h0000, -1);
        send_packet(16'h5AA5, 32'h8765_4321, 9, 16'hFFFF, -1);
    endtask

    task automatic test_oversize_packets();
        send_packet(16'h0001, 32'hDEAD_BEEF, MAX_PACKET_BYTES, 16'h0102, -1);
        send_packet(16'h0002, 32'h0BAD_F00D, MAX_PACKET_BYTES + 2, 16'h0304, -1);
        wait_for_results();
    endtask

    task automatic send_random_packet();
        int          pick;
        int          len;
        int          clear_at;
        logic [15:0] seq;
        pick = $urandom_range(99);
        clear_at = -1;
        if (pick < 6) begin
            send_word(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 78) begin
            len = 8 + 2 * $urandom_range(14);
        end else if (pick < 86) begin
            len = $urandom_range(1, 7);
        end else if (pick < 94) begin
            len = 9 + 2 * $urandom_range(14);
        end else begin
            len = 8 + 2 * $urandom_range(14);
            clear_at = $urandom_range(len - 1);
        end
        pick = $urandom_range(99);
        if (pick < 55)       seq = seq_last + 16'd1;
        else if (pick < 68)  seq = seq_last + 16'd1 + 16'($urandom_range(1, 20));
        else if (pick < 76)  seq = seq_last - 16'($urandom_range(8));
        else if (pick < 82)  seq = 16'hFFF8 + 16'($urandom_range(7));
        else if (pick < 88)  seq = 16'h7FFE + 16'($urandom_range(4));
        else                 seq = 16'($urandom_range(16'hFFFF));
        send_packet(seq, $urandom, len, 16'($urandom_range(16'hFFFF)), clear_at);
    endtask

    task automatic test_random_packets(int send_pct, int recv_pct, int n_words);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = words_sent + n_words;
        while (words_sent < target) send_random_packet();
        // hold off until the block has flushed everything
        wait_for_results();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        pos_r    = '0;
        hdr_seq  = '0;
        hdr_ts   = '0;
        low_byte = '0;
        clear_tracking();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 62;
        test_header_extremes();
        test_length_rejects();
        test_oversize_packets();
        test_random_packets(35, 62, 350);
        test_random_packets(62, 35, 350);
        test_random_packets(0, 0, 350);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (deframed_q.size() != 0)
            $display("%0d expected words never arrived", deframed_q.size());
        if (mismatches == 0 && deframed_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
